// ===== hdl/diff_drive_odometry_assert.svh =====
// Assertion macros shared by the odometry checker.
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define DDO_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define DDO_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ddo_pkg.sv =====
// Types, constants and the arctangent table for the odometry block.
package ddo_pkg;

   localparam int DefCordicSteps = 16;
   localparam int MaxCordicSteps = 24;
   localparam int CsrAddrW = 3;
   localparam logic [23:0] ItwReset = 24'd65536;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam logic [23:0] InvTwoPiQ20 = 24'd166886;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_LOAD,
      ST_MUL,
      ST_NEXT,
      ST_DONE
   } ddo_state_type;

   typedef enum logic [2:0] {
      OP_W,
      OP_T,
      OP_DH,
      OP_VC,
      OP_XD,
      OP_VS,
      OP_YD
   } ddo_op_type;

   localparam logic [0:0] REG_ITW = 1'b0;

   // atan(2^-i) in units where 2^32 is one full turn.
   function automatic logic [31:0] atan_units(input logic [4:0] idx);
      logic [31:0] r;
      begin
         case (idx)
            5'd0: r = 32'd536870912;
            5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;
            5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;
            5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;
            5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;
            5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== hdl/diff_drive_odometry.sv =====
// Differential-drive odometry: rates, CORDIC heading and bit-serial pose update.

// One beat on the request channel is taken while the block is idle; its result beat
// is formed by a CORDIC that does one rotation a cycle, then by one shift-and-add
// multiplier that consumes one multiplier bit a cycle and forms seven products in turn
// (turn rate, heading step, and the cosine and sine position steps). A finished
// result waits in its own output register, so a new request beat is taken while the
// previous result is still stalled. The pose resets to the origin with zero heading.
module diff_drive_odometry
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS = DefCordicSteps
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [23:0]   req_vel_right,
   input  logic signed [23:0]   req_vel_left,
   input  logic [19:0]          req_time_step,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_x_position,
   output logic signed [31:0]   rsp_y_position,
   output logic [23:0]          rsp_heading,
   output logic signed [23:0]   rsp_linear_speed,
   output logic signed [23:0]   rsp_angular_rate,
   output logic                 rsp_stationary,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CsrAddrW-1:0]  csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

   ddo_state_type state_ff, state_in;
   ddo_op_type    op_ff, op_in;

   logic [23:0]          itw_ff, itw_in;
   logic signed [31:0]   px_ff, px_in, py_ff, py_in;
   logic [23:0]          ph_ff, ph_in;

   logic signed [23:0]   v_ff, v_in;
   logic signed [24:0]   diff_ff, diff_in;
   logic [19:0]          dt_ff, dt_in;
   logic                 still_ff, still_in;
   logic signed [23:0]   w_ff, w_in;

   logic signed [33:0]   cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic                 flip_ff, flip_in;
   logic [4:0]           ci_ff, ci_in;

   logic signed [63:0]   mcand_ff, mcand_in, acc_ff, acc_in;
   logic [23:0]          mpl_ff, mpl_in;
   logic [4:0]           mlen_ff, mlen_in, mcnt_ff, mcnt_in;
   logic                 msgn_ff, msgn_in;

   logic                 rv_ff, rv_in;
   logic signed [31:0]   ox_ff, ox_in, oy_ff, oy_in;
   logic [23:0]          oh_ff, oh_in;
   logic signed [23:0]   ov_ff, ov_in, ow_ff, ow_in;
   logic                 os_ff, os_in;

   // Scratch values of the combinational block.
   logic signed [24:0]   sum_v, ang;
   logic signed [33:0]   xs, ys, atn;
   logic signed [63:0]   addend, wide;
   logic signed [32:0]   psum;
   logic signed [31:0]   dpos, psat;
   logic                 req_acc, cfg_wr;

   assign req_acc    = req_valid && !req_stall;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ITW) ? {8'd0, itw_ff} : 32'd0;
   assign req_stall  = (state_ff != ST_IDLE);

   assign rsp_valid        = rv_ff;
   assign rsp_x_position   = ox_ff;
   assign rsp_y_position   = oy_ff;
   assign rsp_heading      = oh_ff;
   assign rsp_linear_speed = ov_ff;
   assign rsp_angular_rate = ow_ff;
   assign rsp_stationary   = os_ff;

   // Sequencer: intake, CORDIC rotations, serial products and result hand-over.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      itw_in   = itw_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      ph_in    = ph_ff;
      v_in     = v_ff;
      diff_in  = diff_ff;
      dt_in    = dt_ff;
      still_in = still_ff;
      w_in     = w_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      flip_in  = flip_ff;
      ci_in    = ci_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      mpl_in   = mpl_ff;
      mlen_in  = mlen_ff;
      mcnt_in  = mcnt_ff;
      msgn_in  = msgn_ff;
      rv_in    = rv_ff && rsp_stall;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oh_in    = oh_ff;
      ov_in    = ov_ff;
      ow_in    = ow_ff;
      os_in    = os_ff;

      sum_v  = 25'(req_vel_right) + 25'(req_vel_left);
      ang    = 25'(signed'(ph_ff));
      xs     = cx_ff >>> ci_ff;
      ys     = cy_ff >>> ci_ff;
      atn    = signed'({2'b00, atan_units(ci_ff)});
      addend = ((mcnt_ff == mlen_ff - 5'd1) && msgn_ff) ? -mcand_ff : mcand_ff;
      wide   = acc_ff >>> 16;
      dpos   = acc_ff[63:32];
      psum   = (op_ff == OP_XD) ? (33'(px_ff) + 33'(dpos)) : (33'(py_ff) + 33'(dpos));
      if (psum[32] != psum[31]) begin
         psat = psum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         psat = psum[31:0];
      end

      // Register write from the configuration port.
      if (cfg_wr && (csr_paddr[2] == REG_ITW)) begin
         itw_in = csr_pwdata[23:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               v_in     = sum_v[24:1];
               diff_in  = 25'(req_vel_right) - 25'(req_vel_left);
               dt_in    = req_time_step;
               still_in = (req_vel_right == 24'sd0) && (req_vel_left == 24'sd0);
               // Fold the heading into plus or minus a quarter turn.
               flip_in  = 1'b0;
               if (ang > 25'sd4194304) begin
                  ang     = ang - 25'sd8388608;
                  flip_in = 1'b1;
               end else if (ang < -25'sd4194304) begin
                  ang     = ang + 25'sd8388608;
                  flip_in = 1'b1;
               end
               cz_in    = signed'({ang[24], ang, 8'd0});
               cx_in    = CordicGain;
               cy_in    = 34'sd0;
               ci_in    = 5'd0;
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            // One rotation a cycle, direction from the sign of the residual angle.
            if (!cz_ff[33]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atn;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atn;
            end
            ci_in = ci_ff + 5'd1;
            if (ci_ff == LastStep) begin
               op_in    = OP_W;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Operands of the next product; the previous product is still in acc.
            msgn_in = 1'b0;
            case (op_ff)
               OP_W: begin
                  mcand_in = 64'(diff_ff);
                  mpl_in   = itw_ff;
                  mlen_in  = 5'd24;
               end
               OP_T: begin
                  mcand_in = 64'(w_ff);
                  mpl_in   = 24'(dt_ff);
                  mlen_in  = 5'd20;
               end
               OP_DH: begin
                  mcand_in = acc_ff;
                  mpl_in   = InvTwoPiQ20;
                  mlen_in  = 5'd18;
               end
               OP_VC: begin
                  mcand_in = flip_ff ? -64'(cx_ff) : 64'(cx_ff);
                  mpl_in   = v_ff;
                  mlen_in  = 5'd24;
                  msgn_in  = 1'b1;
               end
               OP_VS: begin
                  mcand_in = flip_ff ? -64'(cy_ff) : 64'(cy_ff);
                  mpl_in   = v_ff;
                  mlen_in  = 5'd24;
                  msgn_in  = 1'b1;
               end
               OP_XD, OP_YD: begin
                  mcand_in = acc_ff >>> 14;
                  mpl_in   = 24'(dt_ff);
                  mlen_in  = 5'd20;
               end
               default: begin
                  mcand_in = 64'sd0;
                  mpl_in   = 24'd0;
                  mlen_in  = 5'd1;
               end
            endcase
            acc_in   = 64'sd0;
            mcnt_in  = 5'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // One multiplier bit a cycle; the top bit of a signed multiplier weighs negative.
            if (mpl_ff[0]) begin
               acc_in = acc_ff + addend;
            end
            mcand_in = mcand_ff <<< 1;
            mpl_in   = mpl_ff >> 1;
            mcnt_in  = mcnt_ff + 5'd1;
            if (mcnt_ff == mlen_ff - 5'd1) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            state_in = ST_LOAD;
            case (op_ff)
               OP_W: begin
                  if (wide > 64'sd8388607) begin
                     w_in = 24'sh7f_ffff;
                  end else if (wide < -64'sd8388608) begin
                     w_in = 24'sh80_0000;
                  end else begin
                     w_in = wide[23:0];
                  end
                  op_in = OP_T;
               end
               OP_T: op_in = OP_DH;
               OP_DH: begin
                  ph_in = ph_ff + acc_ff[51:28];
                  op_in = OP_VC;
               end
               OP_VC: op_in = OP_XD;
               OP_XD: begin
                  px_in = psat;
                  op_in = OP_VS;
               end
               OP_VS: op_in = OP_YD;
               OP_YD: begin
                  py_in    = psat;
                  state_in = ST_DONE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               ox_in    = px_ff;
               oy_in    = py_ff;
               oh_in    = ph_ff;
               ov_in    = v_ff;
               ow_in    = w_ff;
               os_in    = still_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state and pose are cleared by reset; working registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_W;
         itw_ff   <= ItwReset;
         px_ff    <= 32'sd0;
         py_ff    <= 32'sd0;
         ph_ff    <= 24'd0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         itw_ff   <= itw_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         ph_ff    <= ph_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      diff_ff  <= diff_in;
      dt_ff    <= dt_in;
      still_ff <= still_in;
      w_ff     <= w_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      flip_ff  <= flip_in;
      ci_ff    <= ci_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      mpl_ff   <= mpl_in;
      mlen_ff  <= mlen_in;
      mcnt_ff  <= mcnt_in;
      msgn_ff  <= msgn_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      oh_ff    <= oh_in;
      ov_ff    <= ov_in;
      ow_ff    <= ow_in;
      os_ff    <= os_in;
   end

endmodule

// ===== hdl/ddo_checker.sv =====
// Port-level checks on the odometry block, bound to its top level.
`include "diff_drive_odometry_assert.svh"

module ddo_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic signed [31:0]   rsp_x_position,
   input logic [23:0]          rsp_heading,
   input logic signed [23:0]   rsp_linear_speed,
   input logic signed [23:0]   rsp_angular_rate,
   input logic                 rsp_stationary
);

   // No result beat straight out of reset.
   `DDO_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "result after reset")

   // A still robot reports zero speed and zero turn rate.
   `DDO_ASSERT(a_still_rates, clock, reset,
      rsp_valid && rsp_stationary |-> rsp_linear_speed == 24'sd0 && rsp_angular_rate == 24'sd0,
      "stationary with non-zero rates")

   // A taken request keeps the block busy on the next cycle.
   `DDO_ASSERT(a_busy_after_req, clock, reset,
      req_valid && !req_stall |=> req_stall, "request taken while busy was expected")

   // A stalled result keeps its pose.
   `DDO_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_position) && $stable(rsp_heading),
      "stalled result changed")

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the differential-drive odometry block.
module testbench;
   import ddo_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CordicIters = DefCordicSteps;
   localparam int SettleCycles = 400;
   localparam int StallLimit = 6000;
   localparam logic [CsrAddrW-1:0] ADDR_ITW = CsrAddrW'(4 * REG_ITW);
   localparam logic [CsrAddrW-1:0] ADDR_UNMAPPED = CsrAddrW'(4);

   typedef struct packed {
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
      logic [23:0]        hdg;
      logic signed [23:0] lin_speed;
      logic signed [23:0] ang_rate;
      logic               still;
   } pose_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_vel_right = '0;
   logic signed [23:0] req_vel_left = '0;
   logic [19:0] req_time_step = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_x_position;
   logic signed [31:0] rsp_y_position;
   logic [23:0] rsp_heading;
   logic signed [23:0] rsp_linear_speed;
   logic signed [23:0] rsp_angular_rate;
   logic rsp_stationary;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   diff_drive_odometry dut (.*);

   // Shadow of the block's pose and register.
   logic [23:0] track_recip;
   longint pose_x_q, pose_y_q;
   logic [23:0] pose_hdg_q;
   pose_report_type pose_reports_due[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   bit receiver_hold = 1'b0;
   int mismatches = 0;
   int beats_in = 0;
   int beats_out = 0;
   int quiet_cycles = 0;

   // Arctangent of 2^-i, 2^32 units per turn.
   const longint atan_step[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Advance the shadow pose by one sample and return the report it gives.
   function automatic pose_report_type advance_pose(logic signed [23:0] vr,
                                                    logic signed [23:0] vl,
                                                    logic [19:0] dt);
      pose_report_type r;
      longint v, w, a, z, cx, cy, xs, ys, dh, dtl;
      bit flip;
      dtl = longint'(dt);
      v = (longint'(vr) + longint'(vl)) >>> 1;
      w = clamp(((longint'(vr) - longint'(vl)) * longint'(track_recip)) >>> 16,
                -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1);
      // Fold the old heading into plus or minus a quarter turn for the CORDIC.
      a = longint'($signed(pose_hdg_q));
      flip = 1'b0;
      if (a > (64'sd1 <<< 22)) begin
         a -= 64'sd1 <<< 23;
         flip = 1'b1;
      end else if (a < -(64'sd1 <<< 22)) begin
         a += 64'sd1 <<< 23;
         flip = 1'b1;
      end
      z = a * 256;
      cx = 652032874;
      cy = 0;
      for (int i = 0; i < CordicIters; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (z >= 0) begin
            cx -= ys;
            cy += xs;
            z -= atan_step[i];
         end else begin
            cx += ys;
            cy -= xs;
            z += atan_step[i];
         end
      end
      if (flip) begin
         cx = -cx;
         cy = -cy;
      end
      pose_x_q = clamp(pose_x_q + ((((v * cx) >>> 14) * dtl) >>> 32),
                       -64'sd2147483648, 64'sd2147483647);
      pose_y_q = clamp(pose_y_q + ((((v * cy) >>> 14) * dtl) >>> 32),
                       -64'sd2147483648, 64'sd2147483647);
      dh = (w * dtl * 166886) >>> 28;
      pose_hdg_q = pose_hdg_q + dh[23:0];
      r.x_pos = pose_x_q[31:0];
      r.y_pos = pose_y_q[31:0];
      r.hdg = pose_hdg_q;
      r.lin_speed = v[23:0];
      r.ang_rate = w[23:0];
      r.still = (vr == 0) && (vl == 0);
      return r;
   endfunction

   // Offer one sample, idling first at the current rate; valid stays high afterwards.
   task automatic send_sample(logic signed [23:0] vr, logic signed [23:0] vl,
                              logic [19:0] dt);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vel_right <= vr;
      req_vel_left <= vl;
      req_time_step <= dt;
      do @(posedge clock); while (req_stall);
      pose_reports_due.push_back(advance_pose(vr, vl, dt));
      beats_in++;
   endtask

   // Let every outstanding report drain, then let the block settle.
   task automatic drain;
      @(posedge clock);
      req_valid <= 1'b0;
      wait (pose_reports_due.size() == 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrAddrW-1:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_ITW) track_recip = data[23:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_speed(bit narrow);
      if (narrow) return 24'($signed($urandom_range(2 * 65536 * 3)) - 65536 * 3);
      return 24'($urandom);
   endfunction

   // Extremes of every field, a standstill, zero and full time steps, turn saturation.
   task automatic test_directed;
      send_sample(0, 0, 20'hFFFFF);
      send_sample(24'sh7FFFFF, 24'sh7FFFFF, 20'd0);
      send_sample(24'sh7FFFFF, 24'sh7FFFFF, 20'd6554);
      send_sample(-24'sh800000, -24'sh800000, 20'd6554);
      send_sample(24'sh7FFFFF, -24'sh800000, 20'd100);
      send_sample(-24'sh800000, 24'sh7FFFFF, 20'd100);
      send_sample(24'sh010000, 24'sh010000, 20'hFFFFF);
      send_sample(24'sh010000, -24'sh010000, 20'd25736);
      send_sample(24'sh010000, -24'sh010000, 20'd51472);
      send_sample(24'sh020000, 24'sh010000, 20'hFFFFF);
      send_sample(-24'sh000001, 24'sh000000, 20'd1);
      send_sample(24'sh000001, 24'sh000000, 20'd1);
      drain();
      // Widest track reciprocal saturates the turn rate.
      csr_write(ADDR_ITW, 32'h00FFFFFF);
      send_sample(24'sh7FFFFF, -24'sh800000, 20'd300);
      send_sample(-24'sh800000, 24'sh7FFFFF, 20'd300);
      send_sample(24'sh000100, 24'sh000000, 20'd1000);
      drain();
      // A zero reciprocal gives no turn at all.
      csr_write(ADDR_ITW, 32'h0);
      send_sample(24'sh7FFFFF, -24'sh800000, 20'hFFFFF);
      send_sample(24'sh010000, 24'sh000000, 20'd65536);
      drain();
      // A write to an unmapped address is dropped.
      csr_write(ADDR_ITW, 32'd1);
      csr_write(ADDR_UNMAPPED, 32'hFFFFFFFF);
      send_sample(24'sh7FFFFF, -24'sh800000, 20'hFFFFF);
      send_sample(-24'sh123456, 24'sh345678, 20'd4000);
      drain();
   endtask

   // Random samples, mostly narrow so the pose keeps moving before it saturates.
   task automatic test_random(int count, int idle_pct, int stall_pct);
      bit narrow;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         narrow = $urandom_range(99) < 60;
         send_sample(rand_speed(narrow), rand_speed(narrow),
                     narrow ? 20'($urandom_range(32767)) : 20'($urandom));
      end
      drain();
   endtask

   // The receiver holds off for a long stretch while samples keep coming.
   task automatic test_backpressure;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      receiver_hold = 1'b1;
      fork
         begin
            repeat (1500) @(posedge clock);
            receiver_hold = 1'b0;
         end
         for (int n = 0; n < 20; n++)
            send_sample(rand_speed(1'b1), rand_speed(1'b1), 20'($urandom_range(9999)));
      join
      drain();
   endtask

   // Compare each report beat against the oldest expectation, then pick the next stall.
   always @(posedge clock) begin
      pose_report_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_x_position, rsp_y_position, rsp_heading, rsp_linear_speed,
                    rsp_angular_rate, rsp_stationary};
            beats_out++;
            if (pose_reports_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected report beat: %p", got);
            end else begin
               want = pose_reports_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Report %0d mismatch: expected %p, got %p",
                              beats_out, want, got);
               end
            end
         end
         rsp_stall <= receiver_hold || ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Watchdog on cycles with no beat on either channel and no configuration access.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         quiet_cycles <= 0;
      else if (quiet_cycles >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      track_recip = ItwReset;
      pose_x_q = 0;
      pose_y_q = 0;
      pose_hdg_q = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      csr_write(ADDR_ITW, 32'h00010000);
      test_random(150, 0, 0);
      csr_write(ADDR_ITW, 32'($urandom_range(1, 16777215)));
      test_random(150, 75, 0);
      csr_write(ADDR_ITW, 32'h00FFFFFF);
      test_random(150, 0, 75);
      csr_write(ADDR_ITW, 32'($urandom_range(1, 262144)));
      test_random(150, 14, 14);
      test_backpressure();
      $display("Covered %0d samples in, %0d reports out, over six track settings,",
               beats_in, beats_out);
      $display("with idle and stall mixes and one long receiver hold-off.");
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
